FILE: rtl/lru_key_value_cache_defines.svh
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LKV_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lru_kv_pkg.sv
// Shared constants and types for the LRU key-value cache.
`timescale 1ns / 1ps
package lru_kv_pkg;

    localparam int DEF_ENTRIES  = 16;
    localparam int DEF_KEY_BITS = 16;

    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;
    localparam int IN_KEY_W  = 16;
    localparam int VALUE_W   = 32;

    localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_HIT,
        UPD_EVICT,
        UPD_FILL
    } upd_mode_t;

    // update broadcast to every cell
    typedef struct packed {
        upd_mode_t mode;
        logic      wr_value;
    } upd_cmd_t;

endpackage

FILE: rtl/lru_kv_cell.sv
// One cache entry: key/value store, recency rank, and a stage of the search chain.
`timescale 1ns / 1ps
module lru_kv_cell #(
    parameter int ENTRIES  = lru_kv_pkg::DEF_ENTRIES,
    parameter int KEY_BITS = lru_kv_pkg::DEF_KEY_BITS,
    parameter int IDX      = 0,
    localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [KEY_BITS-1:0]             key_in,
    input  logic [lru_kv_pkg::VALUE_W-1:0]  value_in,
    input  lru_kv_pkg::upd_cmd_t            upd,
    input  logic [RANK_W-1:0]               limit,
    input  logic [CNT_W-1:0]                count,
    input  logic                            chain_hit_i,
    input  logic [RANK_W-1:0]               chain_rank_i,
    input  logic [lru_kv_pkg::VALUE_W-1:0]  chain_value_i,
    output logic                            chain_hit_o,
    output logic [RANK_W-1:0]               chain_rank_o,
    output logic [lru_kv_pkg::VALUE_W-1:0]  chain_value_o,
    output logic                            match_o
);

    logic                           valid_reg;
    logic [KEY_BITS-1:0]            key_reg;
    logic [lru_kv_pkg::VALUE_W-1:0] value_reg;
    logic [RANK_W-1:0]              rank_reg;
    logic                           hit_reg;
    logic [RANK_W-1:0]              hit_rank_reg;
    logic [lru_kv_pkg::VALUE_W-1:0] hit_value_reg;

    logic match;
    logic target;
    logic age;

    assign match   = valid_reg && (key_reg == key_in);
    assign match_o = match;

    always_comb begin
        target = 1'b0;
        age    = 1'b0;
        unique case (upd.mode)
            lru_kv_pkg::UPD_HIT: begin
                target = match;
                age    = valid_reg && !match && (rank_reg < limit);
            end
            lru_kv_pkg::UPD_EVICT: begin
                target = valid_reg && (rank_reg == limit);
                age    = valid_reg && !target && (rank_reg < limit);
            end
            lru_kv_pkg::UPD_FILL: begin
                target = (CNT_W'(IDX) == count);
                age    = valid_reg && !target;
            end
            default: begin
                target = 1'b0;
                age    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            hit_reg   <= 1'b0;
        end else begin
            // search chain: OR this entry's hit into the word from the left
            hit_reg       <= chain_hit_i | match;
            hit_rank_reg  <= chain_rank_i | (match ? rank_reg : '0);
            hit_value_reg <= chain_value_i | (match ? value_reg : '0);

            if (target) begin
                rank_reg <= '0;
                if (upd.mode == lru_kv_pkg::UPD_FILL) begin
                    valid_reg <= 1'b1;
                end
                if (upd.mode != lru_kv_pkg::UPD_HIT) begin
                    key_reg <= key_in;
                end
                if (upd.wr_value || upd.mode != lru_kv_pkg::UPD_HIT) begin
                    value_reg <= value_in;
                end
            end else if (age) begin
                rank_reg <= rank_reg + RANK_W'(1);
            end
        end
    end

    assign chain_hit_o   = hit_reg;
    assign chain_rank_o  = hit_rank_reg;
    assign chain_value_o = hit_value_reg;

endmodule

FILE: rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
`timescale 1ns / 1ps
// Fully associative key-value cache with least-recently-used replacement.
// Input channel s_axis: tuser is the command (0 get, 1 put), tdata holds the
// key and the value to store. Output channel m_axis: one word per get, tuser
// is the found flag, tdata the stored value or all ones on a miss. A put
// gives no output word.
// cfg_wr_en/cfg_wr_data set the capacity (0 acts as 1, above ENTRIES as
// ENTRIES); write it only while the cache is idle.
// An item is accepted, then the search word ripples through the row of
// entry cells one register per cell, and then all cells update their ranks
// in parallel. A get's word appears on m_axis the cycle after that update.
// One item is in flight at a time; the next is taken once the update is
// done.
// If the receiver stalls, the result waits in the output register; a new item
// is still accepted and searched, and a get holds in its update cycle until
// the output register is free.
// Reset empties the cache and sets the capacity to 16.
`include "lru_key_value_cache_defines.svh"
module lru_key_value_cache #(
    parameter int ENTRIES  = lru_kv_pkg::DEF_ENTRIES,
    parameter int KEY_BITS = lru_kv_pkg::DEF_KEY_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // [15:0] lookup_key, [47:16] new_value
    input  logic        s_axis_tuser,  // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] read_value
    output logic        m_axis_tuser,  // [0] found
    input  logic        cfg_wr_en,
    input  logic [lru_kv_pkg::CAP_W-1:0] cfg_wr_data
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > lru_kv_pkg::CAP_W) ? CNT_W : lru_kv_pkg::CAP_W;
    localparam int VW     = lru_kv_pkg::VALUE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPD
    } state_t;

    state_t                         state_reg;
    logic [RANK_W-1:0]              scnt_reg;
    logic                           cmd_reg;
    logic [KEY_BITS-1:0]            key_reg;
    logic [VW-1:0]                  val_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [lru_kv_pkg::CAP_W-1:0]   cap_reg;
    logic                           m_valid_reg;
    logic                           m_found_reg;
    logic [VW-1:0]                  m_data_reg;

    logic [KEY_BITS+lru_kv_pkg::IN_KEY_W-1:0] key_ext;
    logic [CMP_W-1:0]               cap_eff;
    logic [CNT_W-1:0]               count_dec;
    logic [RANK_W-1:0]              last_rank;
    logic                           out_free;
    logic                           go;
    lru_kv_pkg::upd_cmd_t           upd;
    logic [RANK_W-1:0]              limit;

    logic              chain_hit   [0:ENTRIES];
    logic [RANK_W-1:0] chain_rank  [0:ENTRIES];
    logic [VW-1:0]     chain_value [0:ENTRIES];
    logic [ENTRIES-1:0] match_vec;

    assign key_ext = {{KEY_BITS{1'b0}}, s_axis_tdata[15:0]};

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CMP_W'(1);
        end else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = CMP_W'(cap_reg);
        end
    end

    assign count_dec = count_reg - CNT_W'(1);
    assign last_rank = count_dec[RANK_W-1:0];
    assign out_free  = !m_valid_reg || m_axis_tready;

    always_comb begin
        upd.mode     = lru_kv_pkg::UPD_NONE;
        upd.wr_value = 1'b0;
        limit        = chain_rank[ENTRIES];
        go           = 1'b0;
        if (state_reg == S_UPD) begin
            if (cmd_reg == lru_kv_pkg::CMD_GET) begin
                go = out_free;
                if (go && chain_hit[ENTRIES]) begin
                    upd.mode = lru_kv_pkg::UPD_HIT;
                end
            end else begin
                go = 1'b1;
                priority if (chain_hit[ENTRIES]) begin
                    upd.mode     = lru_kv_pkg::UPD_HIT;
                    upd.wr_value = 1'b1;
                end else if (CMP_W'(count_reg) >= cap_eff) begin
                    upd.mode = lru_kv_pkg::UPD_EVICT;
                    limit    = last_rank;
                end else begin
                    upd.mode = lru_kv_pkg::UPD_FILL;
                end
            end
        end
    end

    assign chain_hit[0]   = 1'b0;
    assign chain_rank[0]  = '0;
    assign chain_value[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        lru_kv_cell #(
            .ENTRIES  (ENTRIES),
            .KEY_BITS (KEY_BITS),
            .IDX      (i)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .key_in        (key_reg),
            .value_in      (val_reg),
            .upd           (upd),
            .limit         (limit),
            .count         (count_reg),
            .chain_hit_i   (chain_hit[i]),
            .chain_rank_i  (chain_rank[i]),
            .chain_value_i (chain_value[i]),
            .chain_hit_o   (chain_hit[i+1]),
            .chain_rank_o  (chain_rank[i+1]),
            .chain_value_o (chain_value[i+1]),
            .match_o       (match_vec[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            scnt_reg    <= '0;
            count_reg   <= '0;
            cap_reg     <= lru_kv_pkg::CAP_W'(lru_kv_pkg::CAP_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (state_reg == S_UPD && go && cmd_reg == lru_kv_pkg::CMD_GET) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        cmd_reg   <= s_axis_tuser;
                        key_reg   <= key_ext[KEY_BITS-1:0];
                        val_reg   <= s_axis_tdata[47:16];
                        scnt_reg  <= RANK_W'(ENTRIES - 1);
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (scnt_reg == '0) begin
                        state_reg <= S_UPD;
                    end else begin
                        scnt_reg <= scnt_reg - RANK_W'(1);
                    end
                end
                S_UPD: begin
                    if (go) begin
                        state_reg <= S_IDLE;
                        if (upd.mode == lru_kv_pkg::UPD_FILL) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        if (cmd_reg == lru_kv_pkg::CMD_GET) begin
                            m_found_reg <= chain_hit[ENTRIES];
                            m_data_reg  <= chain_hit[ENTRIES] ? chain_value[ENTRIES]
                                                              : lru_kv_pkg::MISS_VALUE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_found_reg;
    assign m_axis_tdata  = m_data_reg;

    // keys are unique among valid entries
    `LKV_ASSERT_IMPL(a_single_match, state_reg == S_SEARCH, $onehot0(match_vec),
        "more than one entry matches the key")
    `LKV_ASSERT_IMPL(a_count_bound, 1'b1, CMP_W'(count_reg) <= CMP_W'(ENTRIES),
        "valid count exceeds entry count")
    `LKV_ASSERT_IMPL(a_fill_below_cap, upd.mode == lru_kv_pkg::UPD_FILL,
        CMP_W'(count_reg) < cap_eff, "fill issued with the cache at capacity")
    `LKV_ASSERT_NEXT(a_accept_starts_search, s_axis_tvalid && s_axis_tready,
        state_reg == S_SEARCH, "accepted word did not start a search")
    `LKV_ASSERT_NEXT(a_get_gives_word, state_reg == S_UPD && go && cmd_reg == lru_kv_pkg::CMD_GET,
        m_axis_tvalid, "get finished without an output word")

endmodule
